>>> src/amh_pkg.sv
// ----------------------------------------------------------------------------
// amh_pkg
// Shared types and constants for the addressable min-heap.
// ----------------------------------------------------------------------------
package amh_pkg;

  localparam int CAPACITY    = 1024;
  localparam int VALUE_BITS  = 32;
  localparam int HANDLE_BITS = 10;
  localparam int POS_BITS    = 11;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_MODIFY = 2'd2;
  localparam logic [1:0] OP_QUERY  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_NOT_LIVE  = 2'd3;

  typedef struct packed {
    logic [1:0]             opcode;
    logic [VALUE_BITS-1:0]  value;
    logic [HANDLE_BITS-1:0] handle;
  } in_t;

  typedef struct packed {
    logic [HANDLE_BITS-1:0] new_handle;
    logic [VALUE_BITS-1:0]  min_value;
    logic                   min_valid;
    logic [POS_BITS-1:0]    entry_count;
    logic [1:0]             status;
  } out_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_INS_HND, S_INS_SET, S_POP_GONE, S_POP_LAST, S_POP_VAL,
    S_MOD_POS, S_MOD_CHK, S_UP_RD, S_UP_PV, S_UP_CMP, S_UP_END,
    S_DN_L, S_DN_LH, S_DN_RH, S_DN_CMP, S_PLACE, S_MIN0, S_MIN1, S_MIN2, S_EMIT
  } state_t;

endpackage

>>> src/amh_ram.sv
// ----------------------------------------------------------------------------
// amh_ram
// Single-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module amh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> src/addressable_min_heap.sv
// ----------------------------------------------------------------------------
// addressable_min_heap
// Binary min-heap with handles; insert, pop, modify-by-handle, query.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat (in_valid/in_stall, in_data) carries opcode, value, handle.
//   Each input beat yields exactly one output beat (out_valid/out_stall,
//   out_data) with the new minimum, entry count, status and, for insert,
//   the handle assigned.
//   One operation is in flight at a time. Insert may first pop a
//   recycled handle, then walks up level by level until a compare ends
//   the walk or it reaches the root; pop walks down the same way, unless
//   it empties the heap; modify does both walks; query only reads the
//   minimum. The next beat is taken in the cycle after the result is
//   registered. The walks are paced by the single-port order and value
//   RAMs: each heap level costs one order read and one value read per
//   child/parent.
//   Liveness of a handle is checked through the order RAM (its recorded
//   position must point back to it), so no RAM needs clearing.
//   Reset: heap empty, all handles free, ready on the first cycle.
//   Output is registered; the next op is taken while a result waits, and
//   finishes once out_stall drops.
// ----------------------------------------------------------------------------
module addressable_min_heap
  import amh_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  state_t state, state_next;

  logic [1:0]             op;
  logic [VALUE_BITS-1:0]  val;
  logic [HANDLE_BITS-1:0] hnd;
  logic [HANDLE_BITS-1:0] newh;
  logic [HANDLE_BITS-1:0] res_h;
  logic [HANDLE_BITS-1:0] cur_h;
  logic [VALUE_BITS-1:0]  cur_v;
  logic [HANDLE_BITS-1:0] gone;
  logic [HANDLE_BITS-1:0] par_h;
  logic [HANDLE_BITS-1:0] lh;
  logic [HANDLE_BITS-1:0] rh;
  logic [VALUE_BITS-1:0]  lv;
  logic [POS_BITS-1:0]    k;
  logic [1:0]             status;
  logic [VALUE_BITS-1:0]  minv;
  logic [POS_BITS-1:0]    count;
  logic [POS_BITS-1:0]    fresh;
  logic [POS_BITS-1:0]    rc;

  logic                   ord_we, val_we, pos_we, stk_we;
  logic [HANDLE_BITS-1:0] ord_addr, val_addr, pos_addr, stk_addr;
  logic [HANDLE_BITS-1:0] ord_wdata, ord_rdata, stk_wdata, stk_rdata;
  logic [VALUE_BITS-1:0]  val_wdata, val_rdata;
  logic [POS_BITS-1:0]    pos_wdata, pos_rdata;

  logic [POS_BITS:0]      l;
  logic                   has_r, dn_move, dn_right;
  logic [POS_BITS-1:0]    kpar, kdec, pdec;

  amh_ram #(.WIDTH(HANDLE_BITS), .DEPTH(CAPACITY)) u_order (
    .clk, .we(ord_we), .addr(ord_addr), .wdata(ord_wdata), .rdata(ord_rdata));
  amh_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_value (
    .clk, .we(val_we), .addr(val_addr), .wdata(val_wdata), .rdata(val_rdata));
  amh_ram #(.WIDTH(POS_BITS), .DEPTH(CAPACITY)) u_pos (
    .clk, .we(pos_we), .addr(pos_addr), .wdata(pos_wdata), .rdata(pos_rdata));
  amh_ram #(.WIDTH(HANDLE_BITS), .DEPTH(CAPACITY)) u_stack (
    .clk, .we(stk_we), .addr(stk_addr), .wdata(stk_wdata), .rdata(stk_rdata));

  assign in_stall = (state != S_IDLE);
  assign l        = {k, 1'b0};
  assign has_r    = (l < {1'b0, count});
  assign kpar     = (k >> 1) - POS_BITS'(1);
  assign kdec     = k - POS_BITS'(1);
  assign pdec     = pos_rdata - POS_BITS'(1);

  // child choice; right wins ties when both are below the moving value
  always_comb begin
    dn_move  = 1'b0;
    dn_right = 1'b0;
    if (has_r && (lv < cur_v || val_rdata < cur_v)) begin
      dn_move  = 1'b1;
      dn_right = !(lv < val_rdata);
    end else if (lv < cur_v) begin
      dn_move = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    ord_we = 1'b0; ord_addr = '0; ord_wdata = '0;
    val_we = 1'b0; val_addr = '0; val_wdata = '0;
    pos_we = 1'b0; pos_addr = '0; pos_wdata = '0;
    stk_we = 1'b0; stk_addr = '0; stk_wdata = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (op)
          OP_INSERT: begin
            if (count >= POS_BITS'(CAPACITY)) begin
              state_next = S_MIN0;
            end else if (rc != '0) begin
              stk_addr   = HANDLE_BITS'(rc - POS_BITS'(1));
              state_next = S_INS_HND;
            end else begin
              state_next = S_INS_SET;
            end
          end
          OP_POP: begin
            state_next = (count == '0) ? S_MIN0 : S_POP_GONE;
          end
          OP_MODIFY: begin
            pos_addr   = hnd;
            state_next = ({1'b0, hnd} >= fresh) ? S_MIN0 : S_MOD_POS;
          end
          default: state_next = S_MIN0;
        endcase
      end
      S_INS_HND: state_next = S_INS_SET;
      S_INS_SET: begin
        val_we = 1'b1; val_addr = newh; val_wdata = val;
        state_next = S_UP_RD;
      end
      S_POP_GONE: begin
        ord_addr   = HANDLE_BITS'(count - POS_BITS'(1));
        state_next = S_POP_LAST;
      end
      S_POP_LAST: begin
        stk_we = 1'b1; stk_addr = HANDLE_BITS'(rc); stk_wdata = gone;
        val_addr   = ord_rdata;
        state_next = (count == POS_BITS'(1)) ? S_MIN0 : S_POP_VAL;
      end
      S_POP_VAL: state_next = S_DN_L;
      S_MOD_POS: begin
        if (pos_rdata == '0 || pos_rdata > count) begin
          state_next = S_MIN0;
        end else begin
          ord_addr   = HANDLE_BITS'(pdec);
          state_next = S_MOD_CHK;
        end
      end
      S_MOD_CHK: begin
        if (ord_rdata != hnd) begin
          state_next = S_MIN0;
        end else begin
          val_we = 1'b1; val_addr = hnd; val_wdata = val;
          state_next = S_UP_RD;
        end
      end
      S_UP_RD: begin
        if (k == POS_BITS'(1)) begin
          state_next = S_UP_END;
        end else begin
          ord_addr   = HANDLE_BITS'(kpar);
          state_next = S_UP_PV;
        end
      end
      S_UP_PV: begin
        val_addr   = ord_rdata;
        state_next = S_UP_CMP;
      end
      S_UP_CMP: begin
        if (cur_v < val_rdata) begin
          ord_we = 1'b1; ord_addr = HANDLE_BITS'(kdec); ord_wdata = par_h;
          pos_we = 1'b1; pos_addr = par_h; pos_wdata = k;
          state_next = S_UP_RD;
        end else begin
          state_next = S_UP_END;
        end
      end
      S_UP_END: state_next = (op == OP_MODIFY) ? S_DN_L : S_PLACE;
      S_DN_L: begin
        if (l > {1'b0, count}) begin
          state_next = S_PLACE;
        end else begin
          ord_addr   = HANDLE_BITS'(l - (POS_BITS+1)'(1));
          state_next = S_DN_LH;
        end
      end
      S_DN_LH: begin
        val_addr   = ord_rdata;
        ord_addr   = HANDLE_BITS'(l);
        state_next = S_DN_RH;
      end
      S_DN_RH: begin
        val_addr   = ord_rdata;
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (dn_move) begin
          ord_we = 1'b1; ord_addr = HANDLE_BITS'(kdec);
          ord_wdata = dn_right ? rh : lh;
          pos_we = 1'b1; pos_addr = dn_right ? rh : lh; pos_wdata = k;
          state_next = S_DN_L;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        ord_we = 1'b1; ord_addr = HANDLE_BITS'(kdec); ord_wdata = cur_h;
        pos_we = 1'b1; pos_addr = cur_h; pos_wdata = k;
        state_next = S_MIN0;
      end
      S_MIN0: state_next = (count == '0) ? S_EMIT : S_MIN1;
      S_MIN1: begin
        val_addr   = ord_rdata;
        state_next = S_MIN2;
      end
      S_MIN2: state_next = S_EMIT;
      S_EMIT: begin
        if (!out_valid || !out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      fresh     <= '0;
      rc        <= '0;
      out_valid <= 1'b0;
    end else begin
      // in S_EMIT the result register is loaded or kept below
      if (out_valid && !out_stall && state != S_EMIT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op  <= in_data.opcode;
            val <= in_data.value;
            hnd <= in_data.handle;
          end
        end
        S_DISPATCH: begin
          res_h <= '0;
          unique case (op)
            OP_INSERT: begin
              if (count >= POS_BITS'(CAPACITY)) begin
                status <= ST_FULL;
              end else begin
                status <= ST_OK;
                if (rc == '0) begin
                  newh  <= HANDLE_BITS'(fresh);
                  fresh <= fresh + POS_BITS'(1);
                end
              end
            end
            OP_POP:    status <= (count == '0) ? ST_EMPTY : ST_OK;
            OP_MODIFY: status <= ({1'b0, hnd} >= fresh) ? ST_NOT_LIVE : ST_OK;
            default:   status <= ST_OK;
          endcase
        end
        S_INS_HND: begin
          newh <= stk_rdata;
          rc   <= rc - POS_BITS'(1);
        end
        S_INS_SET: begin
          count <= count + POS_BITS'(1);
          k     <= count + POS_BITS'(1);
          cur_h <= newh;
          cur_v <= val;
          res_h <= newh;
        end
        S_POP_GONE: gone <= ord_rdata;
        S_POP_LAST: begin
          cur_h <= ord_rdata;
          rc    <= rc + POS_BITS'(1);
          count <= count - POS_BITS'(1);
          k     <= POS_BITS'(1);
        end
        S_POP_VAL: cur_v <= val_rdata;
        S_MOD_POS: begin
          if (pos_rdata == '0 || pos_rdata > count) status <= ST_NOT_LIVE;
          k <= pos_rdata;
        end
        S_MOD_CHK: begin
          if (ord_rdata != hnd) status <= ST_NOT_LIVE;
          cur_h <= hnd;
          cur_v <= val;
        end
        S_UP_PV: par_h <= ord_rdata;
        S_UP_CMP: if (cur_v < val_rdata) k <= k >> 1;
        S_DN_LH: lh <= ord_rdata;
        S_DN_RH: begin
          lv <= val_rdata;
          rh <= ord_rdata;
        end
        S_DN_CMP: begin
          if (dn_move) k <= dn_right ? POS_BITS'(l + (POS_BITS+1)'(1)) : POS_BITS'(l);
        end
        S_MIN0: if (count == '0) minv <= '0;
        S_MIN2: minv <= val_rdata;
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid            <= 1'b1;
            out_data.new_handle  <= res_h;
            out_data.min_value   <= minv;
            out_data.min_valid   <= (count != '0);
            out_data.entry_count <= count;
            out_data.status      <= status;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // every handle handed out is either live or on the free stack
  a_handle_balance: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |->
      ((POS_BITS+1)'(count) + (POS_BITS+1)'(rc) == (POS_BITS+1)'(fresh)))
    else $error("handle accounting broken");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= POS_BITS'(CAPACITY))
    else $error("entry count above capacity");

  // count changes only in the steps that insert or remove
  a_count_steps: assert property (@(posedge clk) disable iff (rst)
    (state != S_INS_SET && state != S_POP_LAST) |=> $stable(count))
    else $error("entry count changed outside insert/pop");
`endif

endmodule

>>> tb/tb_addressable_min_heap.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_addressable_min_heap
// Drives insert, pop, modify and query beats into the heap with random gaps
// and output stalls, and checks every result against a behavioral heap.
// ----------------------------------------------------------------------------
module tb_addressable_min_heap
  import amh_pkg::*;
();

  localparam int CYCLE_LIMIT = 1000000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  addressable_min_heap dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // behavioral heap state
  logic [HANDLE_BITS-1:0] heap_slot [0:CAPACITY];
  logic [VALUE_BITS-1:0]  key_of    [0:CAPACITY-1];
  logic [POS_BITS-1:0]    pos_of    [0:CAPACITY-1];
  bit                     is_live   [0:CAPACITY-1];
  logic [HANDLE_BITS-1:0] free_stack[$];
  int                     heap_size;
  int                     next_fresh;

  out_t   result_queue[$];
  int     fail_count;
  int     cycle_count;
  bit     hold_output;
  bit     long_hold_req;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [VALUE_BITS-1:0] key_at(int p);
    return key_of[heap_slot[p]];
  endfunction

  function automatic void swap_slots(int a, int b);
    logic [HANDLE_BITS-1:0] ha, hb;
    ha = heap_slot[a];
    hb = heap_slot[b];
    heap_slot[a] = hb;
    heap_slot[b] = ha;
    pos_of[hb] = POS_BITS'(a);
    pos_of[ha] = POS_BITS'(b);
  endfunction

  function automatic void bubble_up(int k);
    while (k > 1 && key_at(k) < key_at(k / 2)) begin
      swap_slots(k, k / 2);
      k = k / 2;
    end
  endfunction

  function automatic void bubble_down(int k);
    int l, r, c;
    forever begin
      l = 2 * k;
      r = l + 1;
      if (r <= heap_size && (key_at(l) < key_at(k) || key_at(r) < key_at(k))) begin
        c = (key_at(l) < key_at(r)) ? l : r;
        swap_slots(k, c);
        k = c;
      end else if (l <= heap_size && key_at(l) < key_at(k)) begin
        swap_slots(k, l);
        k = l;
      end else begin
        break;
      end
    end
  endfunction

  function automatic out_t apply_heap_op(in_t op);
    out_t res;
    logic [HANDLE_BITS-1:0] h, gone;
    res = '0;
    res.status = ST_OK;
    case (op.opcode)
      OP_INSERT: begin
        if (heap_size >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          if (free_stack.size() > 0) begin
            h = free_stack.pop_back();
          end else begin
            h = next_fresh[HANDLE_BITS-1:0];
            next_fresh++;
          end
          heap_size++;
          key_of[h] = op.value;
          is_live[h] = 1'b1;
          pos_of[h] = POS_BITS'(heap_size);
          heap_slot[heap_size] = h;
          bubble_up(heap_size);
          res.new_handle = h;
        end
      end
      OP_POP: begin
        if (heap_size == 0) begin
          res.status = ST_EMPTY;
        end else begin
          gone = heap_slot[1];
          swap_slots(1, heap_size);
          heap_size--;
          is_live[gone] = 1'b0;
          free_stack.push_back(gone);
          bubble_down(1);
        end
      end
      OP_MODIFY: begin
        if (!is_live[op.handle]) begin
          res.status = ST_NOT_LIVE;
        end else begin
          key_of[op.handle] = op.value;
          bubble_up(pos_of[op.handle]);
          bubble_down(pos_of[op.handle]);
        end
      end
      default: ;
    endcase
    res.min_valid = heap_size > 0;
    res.min_value = heap_size > 0 ? key_at(1) : '0;
    res.entry_count = POS_BITS'(heap_size);
    return res;
  endfunction

  // pick a live handle, or any handle if none is live
  function automatic logic [HANDLE_BITS-1:0] some_live_handle();
    if (heap_size == 0) return HANDLE_BITS'($urandom_range(0, CAPACITY - 1));
    return heap_slot[$urandom_range(1, heap_size)];
  endfunction

  task automatic send_op(logic [1:0] opc, logic [VALUE_BITS-1:0] val,
                         logic [HANDLE_BITS-1:0] hnd);
    in_t beat;
    int  g;
    g = gap_len();
    repeat (g) @(posedge clk);
    beat.opcode = opc;
    beat.value  = val;
    beat.handle = hnd;
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    result_queue.push_back(apply_heap_op(beat));
    in_valid <= 1'b0;
    // block is busy after a beat anyway
    @(posedge clk);
  endtask

  // output stall generator
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        long_hold_req = 0;
      end else if (hold_output) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        n = gap_len();
        out_stall <= (n > 0);
        repeat (n > 0 ? n : $urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (result_queue.size() == 0) begin
        $error("unexpected result beat");
        fail_count++;
      end else begin
        want = result_queue.pop_front();
        if (out_data.new_handle !== want.new_handle) begin
          $error("new_handle exp %0d got %0d", want.new_handle, out_data.new_handle);
          fail_count++;
        end
        if (out_data.min_value !== want.min_value) begin
          $error("min_value exp %0h got %0h", want.min_value, out_data.min_value);
          fail_count++;
        end
        if (out_data.min_valid !== want.min_valid) begin
          $error("min_valid exp %0b got %0b", want.min_valid, out_data.min_valid);
          fail_count++;
        end
        if (out_data.entry_count !== want.entry_count) begin
          $error("entry_count exp %0d got %0d", want.entry_count, out_data.entry_count);
          fail_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, out_data.status);
          fail_count++;
        end
      end
    end
  end

  task automatic test_directed();
    send_op(OP_POP, '0, '0);                 // pop from empty
    send_op(OP_QUERY, '1, '1);
    send_op(OP_MODIFY, 32'h5, 10'd0);       // handle never issued
    send_op(OP_INSERT, 32'hFFFF_FFFF, '0);
    send_op(OP_INSERT, 32'h0, '1);
    send_op(OP_INSERT, 32'h10, '0);
    send_op(OP_INSERT, 32'h10, '0);         // moves up past the larger key
    send_op(OP_INSERT, 32'h10, '0);
    send_op(OP_MODIFY, 32'h8, 10'd1);       // increase key at root
    send_op(OP_MODIFY, 32'h1, 10'd0);       // decrease key
    send_op(OP_MODIFY, 32'h20, 10'd1023);   // not live
    send_op(OP_POP, '0, '0);
    send_op(OP_POP, '0, '0);                // handles to recycle
    send_op(OP_INSERT, 32'h7, '0);
    send_op(OP_MODIFY, 32'h7, 10'd0);
    send_op(OP_QUERY, '0, '0);
    repeat (6) send_op(OP_POP, '0, '0);     // drain past empty
  endtask

  task automatic test_random(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40)
        send_op(OP_INSERT, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom(), '0);
      else if (r < 65)
        send_op(OP_POP, $urandom(), HANDLE_BITS'($urandom()));
      else if (r < 90)
        send_op(OP_MODIFY, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom(),
                ($urandom_range(0, 4) == 0) ? HANDLE_BITS'($urandom_range(0, CAPACITY - 1))
                                            : some_live_handle());
      else
        send_op(OP_QUERY, $urandom(), HANDLE_BITS'($urandom()));
    end
  endtask

  // fill to capacity, hit full, then drain a bit
  task automatic test_full();
    while (heap_size < CAPACITY)
      send_op(OP_INSERT, $urandom(), '0);
    send_op(OP_INSERT, $urandom(), '1);
    send_op(OP_MODIFY, 32'h0, some_live_handle());
    repeat (40) send_op(OP_POP, '0, '0);
  endtask

  task automatic test_backpressure();
    long_hold_req = 1;
    repeat (20) send_op(OP_INSERT, $urandom(), '0);
    wait (!long_hold_req);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    hold_output = 0;
    long_hold_req = 0;
    fail_count = 0;
    cycle_count = 0;
    heap_size = 0;
    next_fresh = 0;
    for (int i = 0; i < CAPACITY; i++) is_live[i] = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(80);
    test_full();
    test_random(40);
    hold_output = 1;
    while (result_queue.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
